>>> hdl/binomial_mod_prime_engine_unit_macros.svh
// Assertion helpers shared by the engine's modules.
`ifndef BINOMIAL_MOD_PRIME_ENGINE_UNIT_MACROS_SVH
`define BINOMIAL_MOD_PRIME_ENGINE_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define BMPE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BMPE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/bmpe_pkg.sv
package bmpe_pkg;

   localparam int DefaultTableDepth = 4096;

   localparam int ValueW  = 30;
   localparam int StatusW = 2;
   localparam int FuncW   = 2;
   localparam int ArgW    = 16;

   localparam logic [29:0] PrimeMod = 30'd1000000007;
   localparam logic [29:0] PowExp   = 30'(PrimeMod - 30'd2);
   localparam int          PowSteps = 30;

   // Barrett constant floor(2^60 / P), which fits in 31 bits.
   localparam logic [30:0] BarrettMu = 31'(64'h1000_0000_0000_0000 / 64'd1000000007);

   typedef enum logic [1:0] {
      FuncBuild = 2'd0,
      FuncComb  = 2'd1,
      FuncPerm  = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      StatusOk       = 2'd0,
      StatusDepth    = 2'd1,
      StatusNotBuilt = 2'd2
   } status_type;

   typedef struct packed {
      logic        go;
      logic [29:0] a;
      logic [29:0] b;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      logic [29:0] p;
   } mul_rsp_type;

   typedef struct packed {
      logic fact_we;
      logic inv_we;
      logic fact_re;
      logic inv_re;
   } mem_ctl_type;

endpackage

>>> hdl/bmpe_mulmod.sv
`include "binomial_mod_prime_engine_unit_macros.svh"

module bmpe_mulmod (
   input  logic                  clock,
   input  logic                  reset,
   input  bmpe_pkg::mul_req_type mul_req,
   output bmpe_pkg::mul_rsp_type mul_rsp
);
   import bmpe_pkg::*;

   // Five stages: product, quotient estimate, quotient times P, subtract, correct.
   logic [4:0]  v_ff, v_in;
   logic [59:0] prod_ff, prod_in;
   logic [61:0] est_ff, est_in;
   logic [31:0] low1_ff, low1_in;
   logic [31:0] low2_ff, low2_in;
   logic [31:0] qp_ff, qp_in;
   logic [31:0] rem_ff, rem_in;
   logic [29:0] res_ff, res_in;

   localparam logic [31:0] OneP   = 32'(PrimeMod);
   localparam logic [31:0] TwoP   = 32'(PrimeMod) + 32'(PrimeMod);
   localparam logic [31:0] ThreeP = 32'(PrimeMod) + 32'(PrimeMod) + 32'(PrimeMod);

   always_comb begin
      v_in    = {v_ff[3:0], mul_req.go};
      prod_in = 60'(mul_req.a) * 60'(mul_req.b);
      est_in  = 62'(prod_ff[59:29]) * 62'(BarrettMu);
      low1_in = prod_ff[31:0];
      qp_in   = 32'(est_ff[61:31]) * 32'(PrimeMod);
      low2_in = low1_ff;
      rem_in  = low2_ff - qp_ff;
      if (rem_ff >= TwoP) begin
         res_in = 30'(rem_ff - TwoP);
      end else if (rem_ff >= OneP) begin
         res_in = 30'(rem_ff - OneP);
      end else begin
         res_in = 30'(rem_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      est_ff  <= est_in;
      low1_ff <= low1_in;
      qp_ff   <= qp_in;
      low2_ff <= low2_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
   end

   assign mul_rsp.done = v_ff[4];
   assign mul_rsp.p    = res_ff;

   `BMPE_ASSERT_SAME(a_mul_single, clock, reset, 1'b1, $onehot0(v_ff), "more than one multiply in flight")
   `BMPE_ASSERT_SAME(a_mul_rem_bound, clock, reset, v_ff[3], rem_ff < ThreeP, "Barrett remainder out of bound")
   `BMPE_ASSERT_SAME(a_mul_range, clock, reset, mul_rsp.done, mul_rsp.p < PrimeMod, "product not reduced")

endmodule

>>> hdl/bmpe_tables.sv
module bmpe_tables #(
   parameter  int Depth = bmpe_pkg::DefaultTableDepth,
   localparam int AddrW = $clog2(Depth)
) (
   input  logic                  clock,
   input  bmpe_pkg::mem_ctl_type mem_ctl,
   input  logic [AddrW-1:0]      wr_addr,
   input  logic [29:0]           wr_data,
   input  logic [AddrW-1:0]      fact_addr,
   input  logic [AddrW-1:0]      inv_addr,
   output logic [29:0]           fact_data,
   output logic [29:0]           inv_data
);
   import bmpe_pkg::*;

   logic [29:0] fact_mem [Depth];
   logic [29:0] inv_mem  [Depth];
   logic [29:0] fact_rd_ff;
   logic [29:0] inv_rd_ff;

   // Read data holds while no read is enabled.
   always_ff @(posedge clock) begin
      if (mem_ctl.fact_we) begin
         fact_mem[wr_addr] <= wr_data;
      end
      if (mem_ctl.fact_re) begin
         fact_rd_ff <= fact_mem[fact_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.inv_we) begin
         inv_mem[wr_addr] <= wr_data;
      end
      if (mem_ctl.inv_re) begin
         inv_rd_ff <= inv_mem[inv_addr];
      end
   end

   assign fact_data = fact_rd_ff;
   assign inv_data  = inv_rd_ff;

endmodule

>>> hdl/bmpe_ctrl.sv
`include "binomial_mod_prime_engine_unit_macros.svh"

module bmpe_ctrl #(
   parameter  int Depth = bmpe_pkg::DefaultTableDepth,
   localparam int AddrW = $clog2(Depth)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bmpe_pkg::FuncW-1:0]        req_func,
   input  logic [bmpe_pkg::ArgW-1:0]         req_n_total,
   input  logic [bmpe_pkg::ArgW-1:0]         req_r_chosen,
   input  logic                              out_free,
   output logic                              res_valid,
   output logic [bmpe_pkg::ValueW-1:0]       res_value,
   output logic [bmpe_pkg::StatusW-1:0]      res_status,
   output bmpe_pkg::mul_req_type             mul_req,
   input  bmpe_pkg::mul_rsp_type             mul_rsp,
   output bmpe_pkg::mem_ctl_type             mem_ctl,
   output logic [AddrW-1:0]                  wr_addr,
   output logic [29:0]                       wr_data,
   output logic [AddrW-1:0]                  fact_addr,
   output logic [AddrW-1:0]                  inv_addr,
   input  logic [29:0]                       fact_data,
   input  logic [29:0]                       inv_data
);
   import bmpe_pkg::*;

   typedef enum logic [8:0] {
      StIdle   = 9'b000000001,
      StFact   = 9'b000000010,
      StPowMul = 9'b000000100,
      StPowSqr = 9'b000001000,
      StInv    = 9'b000010000,
      StQRead  = 9'b000100000,
      StQMul1  = 9'b001000000,
      StQMul2  = 9'b010000000,
      StResp   = 9'b100000000
   } state_type;

   localparam int              CmpW    = ((AddrW > ArgW) ? AddrW : ArgW) + 1;
   localparam logic [CmpW-1:0] DepthC  = CmpW'(Depth);
   localparam logic [AddrW-1:0] LastIdx = AddrW'(Depth - 1);
   localparam logic [AddrW-1:0] OneIdx  = AddrW'(1);
   localparam logic [4:0]      LastBit = 5'(PowSteps - 1);

   state_type        state_ff, state_in;
   logic [AddrW-1:0] idx_ff, idx_in;
   logic [4:0]       bit_ff, bit_in;
   logic [29:0]      acc_ff, acc_in;
   logic [29:0]      sq_ff, sq_in;
   func_type         func_ff, func_in;
   logic [AddrW-1:0] r_ff, r_in;
   logic             tables_ready_ff, tables_ready_in;
   mul_req_type      mreq_ff, mreq_in;
   logic [29:0]      res_value_ff, res_value_in;
   status_type       res_status_ff, res_status_in;

   logic [CmpW-1:0]  n_cmp;
   logic [CmpW-1:0]  r_cmp;
   logic [CmpW-1:0]  diff_cmp;
   logic [AddrW-1:0] next_idx;
   logic [AddrW-1:0] prev_idx;
   logic [4:0]       next_bit;

   assign n_cmp    = CmpW'(req_n_total);
   assign r_cmp    = CmpW'(req_r_chosen);
   assign diff_cmp = CmpW'(req_n_total - req_r_chosen);
   assign next_idx = idx_ff + OneIdx;
   assign prev_idx = idx_ff - OneIdx;
   assign next_bit = bit_ff + 5'd1;

   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      bit_in          = bit_ff;
      acc_in          = acc_ff;
      sq_in           = sq_ff;
      func_in         = func_ff;
      r_in            = r_ff;
      tables_ready_in = tables_ready_ff;
      mreq_in         = '0;
      res_value_in    = res_value_ff;
      res_status_in   = res_status_ff;
      mem_ctl         = '0;
      wr_addr         = idx_ff;
      wr_data         = mul_rsp.p;
      fact_addr       = n_cmp[AddrW-1:0];
      inv_addr        = diff_cmp[AddrW-1:0];
      req_ready       = 1'b0;
      res_valid       = 1'b0;

      case (state_ff)
         StIdle: begin
            req_ready = 1'b1;
            if (req_valid) begin
               func_in       = func_type'(req_func);
               r_in          = r_cmp[AddrW-1:0];
               res_value_in  = '0;
               res_status_in = StatusOk;
               state_in      = StResp;
               case (func_type'(req_func))
                  FuncBuild: begin
                     mem_ctl.fact_we = 1'b1;
                     wr_addr         = '0;
                     wr_data         = 30'd1;
                     idx_in          = OneIdx;
                     mreq_in.go      = 1'b1;
                     mreq_in.a       = 30'(OneIdx);
                     mreq_in.b       = 30'd1;
                     state_in        = StFact;
                  end
                  FuncComb, FuncPerm: begin
                     if (!tables_ready_ff) begin
                        res_status_in = StatusNotBuilt;
                     end else if (n_cmp >= DepthC) begin
                        res_status_in = StatusDepth;
                     end else if (req_r_chosen <= req_n_total) begin
                        mem_ctl.fact_re = 1'b1;
                        mem_ctl.inv_re  = 1'b1;
                        state_in        = StQRead;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         StFact: begin
            if (mul_rsp.done) begin
               mem_ctl.fact_we = 1'b1;
               mreq_in.go      = 1'b1;
               if (idx_ff == LastIdx) begin
                  sq_in  = mul_rsp.p;
                  acc_in = 30'd1;
                  bit_in = '0;
                  if (PowExp[0]) begin
                     mreq_in.a = 30'd1;
                     mreq_in.b = mul_rsp.p;
                     state_in  = StPowMul;
                  end else begin
                     mreq_in.a = mul_rsp.p;
                     mreq_in.b = mul_rsp.p;
                     state_in  = StPowSqr;
                  end
               end else begin
                  idx_in    = next_idx;
                  mreq_in.a = 30'(next_idx);
                  mreq_in.b = mul_rsp.p;
               end
            end
         end
         StPowMul: begin
            if (mul_rsp.done) begin
               acc_in     = mul_rsp.p;
               mreq_in.go = 1'b1;
               mreq_in.a  = sq_ff;
               mreq_in.b  = sq_ff;
               state_in   = StPowSqr;
            end
         end
         StPowSqr: begin
            if (mul_rsp.done) begin
               sq_in      = mul_rsp.p;
               mreq_in.go = 1'b1;
               if (bit_ff == LastBit) begin
                  mem_ctl.inv_we = 1'b1;
                  wr_addr        = LastIdx;
                  wr_data        = acc_ff;
                  idx_in         = LastIdx;
                  mreq_in.a      = acc_ff;
                  mreq_in.b      = 30'(LastIdx);
                  state_in       = StInv;
               end else begin
                  bit_in = next_bit;
                  if (PowExp[next_bit]) begin
                     mreq_in.a = acc_ff;
                     mreq_in.b = mul_rsp.p;
                     state_in  = StPowMul;
                  end else begin
                     mreq_in.a = mul_rsp.p;
                     mreq_in.b = mul_rsp.p;
                     state_in  = StPowSqr;
                  end
               end
            end
         end
         StInv: begin
            if (mul_rsp.done) begin
               mem_ctl.inv_we = 1'b1;
               wr_addr        = prev_idx;
               idx_in         = prev_idx;
               if (idx_ff == OneIdx) begin
                  tables_ready_in = 1'b1;
                  state_in        = StResp;
               end else begin
                  mreq_in.go = 1'b1;
                  mreq_in.a  = mul_rsp.p;
                  mreq_in.b  = 30'(prev_idx);
               end
            end
         end
         StQRead: begin
            mem_ctl.inv_re = 1'b1;
            inv_addr       = r_ff;
            mreq_in.go     = 1'b1;
            mreq_in.a      = fact_data;
            mreq_in.b      = inv_data;
            state_in       = StQMul1;
         end
         StQMul1: begin
            if (mul_rsp.done) begin
               if (func_ff == FuncComb) begin
                  mreq_in.go = 1'b1;
                  mreq_in.a  = mul_rsp.p;
                  mreq_in.b  = inv_data;
                  state_in   = StQMul2;
               end else begin
                  res_value_in = mul_rsp.p;
                  state_in     = StResp;
               end
            end
         end
         StQMul2: begin
            if (mul_rsp.done) begin
               res_value_in = mul_rsp.p;
               state_in     = StResp;
            end
         end
         StResp: begin
            res_valid = 1'b1;
            if (out_free) begin
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= StIdle;
         tables_ready_ff <= 1'b0;
         mreq_ff         <= '0;
      end else begin
         state_ff        <= state_in;
         tables_ready_ff <= tables_ready_in;
         mreq_ff         <= mreq_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      bit_ff        <= bit_in;
      acc_ff        <= acc_in;
      sq_ff         <= sq_in;
      func_ff       <= func_in;
      r_ff          <= r_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
   end

   assign mul_req    = mreq_ff;
   assign res_value  = res_value_ff;
   assign res_status = res_status_ff;

   `BMPE_ASSERT_SAME(a_idle_no_mul, clock, reset, state_ff == StIdle, !mul_rsp.done, "multiply result arrived while idle")
   `BMPE_ASSERT_SAME(a_idle_no_write, clock, reset, state_ff == StIdle, !mem_ctl.inv_we && (!mem_ctl.fact_we || wr_addr == '0), "table write while idle")
   `BMPE_ASSERT_NEXT(a_ready_sticky, clock, reset, tables_ready_ff, tables_ready_ff, "tables ready flag dropped")
   `BMPE_ASSERT_SAME(a_read_built, clock, reset, mem_ctl.fact_re || mem_ctl.inv_re, tables_ready_ff, "table read before build")

endmodule

>>> hdl/binomial_mod_prime_engine_unit.sv
// Binomial and permutation engine modulo the prime 1000000007.
// The request channel (req_valid/req_ready) takes one word per command: req_func selects
// build (fill the factorial and inverse-factorial tables), combinations or permutations,
// with the arguments in req_n_total and req_r_chosen. Every command returns exactly one
// word on the response channel (rsp_valid/rsp_ready): rsp_value and rsp_status.
// One command is worked at a time. The shared modular multiplier is a five-stage Barrett
// pipeline, and each dependent multiply waits for the previous result to reach the sequencer.
// A combination query takes one more multiply than a permutation query, and a query
// answered from status alone (not built, n beyond the table, r above n, or the unused
// function code) takes none.
// A build walks both tables once and runs the exponentiation to P-2 in between;
// the tables live in two single-write synchronous memories.
// Reset clears the sequencer, the response valid flag and the built flag; the tables keep
// garbage until the first build, and queries before it return status "not built".
// The response sits in an output register, so the engine returns to accept the next word
// while a finished response still waits; it stalls only when a second response is ready
// and the receiver has not yet taken the first.
module binomial_mod_prime_engine_unit #(
   parameter int TABLE_DEPTH = bmpe_pkg::DefaultTableDepth
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [bmpe_pkg::FuncW-1:0]   req_func,
   input  logic [bmpe_pkg::ArgW-1:0]    req_n_total,
   input  logic [bmpe_pkg::ArgW-1:0]    req_r_chosen,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [bmpe_pkg::ValueW-1:0]  rsp_value,
   output logic [bmpe_pkg::StatusW-1:0] rsp_status
);
   import bmpe_pkg::*;

   localparam int AddrW = $clog2(TABLE_DEPTH);

   mul_req_type      mul_req;
   mul_rsp_type      mul_rsp;
   mem_ctl_type      mem_ctl;
   logic [AddrW-1:0] wr_addr;
   logic [29:0]      wr_data;
   logic [AddrW-1:0] fact_addr;
   logic [AddrW-1:0] inv_addr;
   logic [29:0]      fact_data;
   logic [29:0]      inv_data;

   logic               out_free;
   logic               res_valid;
   logic [ValueW-1:0]  res_value;
   logic [StatusW-1:0] res_status;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [ValueW-1:0]  rsp_value_ff, rsp_value_in;
   logic [StatusW-1:0] rsp_status_ff, rsp_status_in;

   bmpe_ctrl #(
      .Depth (TABLE_DEPTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_n_total  (req_n_total),
      .req_r_chosen (req_r_chosen),
      .out_free     (out_free),
      .res_valid    (res_valid),
      .res_value    (res_value),
      .res_status   (res_status),
      .mul_req      (mul_req),
      .mul_rsp      (mul_rsp),
      .mem_ctl      (mem_ctl),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .fact_addr    (fact_addr),
      .inv_addr     (inv_addr),
      .fact_data    (fact_data),
      .inv_data     (inv_data)
   );

   bmpe_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   bmpe_tables #(
      .Depth (TABLE_DEPTH)
   ) u_tables (
      .clock     (clock),
      .mem_ctl   (mem_ctl),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .fact_addr (fact_addr),
      .inv_addr  (inv_addr),
      .fact_data (fact_data),
      .inv_data  (inv_data)
   );

   // The output register is free when empty or when its word leaves this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (res_valid && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = res_value;
         rsp_status_in = res_status;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule
